### rtl/lfp_pkg.sv
// ---------------------------------------------------------------------------
// lfp_pkg - shared types and constants of the lidar frame parser
// Status codes, configuration register indexes and the structures passed
// between the frame core and the top level.
// ---------------------------------------------------------------------------
package lfp_pkg;

    localparam int FRAME_BYTES = 9;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER_VALUE    = 2'd0;
    localparam logic [1:0] CFG_MIN_STRENGTH    = 2'd1;
    localparam logic [1:0] CFG_MIN_DISTANCE_MM = 2'd2;
    localparam logic [1:0] CFG_MAX_DISTANCE_MM = 2'd3;

    // Reset values of the configuration registers
    localparam logic [7:0]  HEADER_VALUE_RST    = 8'd89;
    localparam logic [15:0] MIN_STRENGTH_RST    = 16'd100;
    localparam logic [19:0] MIN_DISTANCE_MM_RST = 20'd200;
    localparam logic [19:0] MAX_DISTANCE_MM_RST = 20'd8000;

    // Temperature field offset, hundredths of a degree
    localparam logic [16:0] TEMP_OFFSET = 17'd25600;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_CHECKSUM = 3'd1,
        STATUS_WEAK     = 3'd2,
        STATUS_NEAR     = 3'd3,
        STATUS_FAR      = 3'd4,
        STATUS_TIMEOUT  = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0]  header_value;
        logic [15:0] min_strength;
        logic [19:0] min_distance_mm;
        logic [19:0] max_distance_mm;
    } cfg_t;

    typedef struct packed {
        status_t            status;
        logic [19:0]        distance_mm;
        logic [15:0]        strength;
        logic signed [16:0] temperature_centi;
        logic [31:0]        error_total;
        logic [31:0]        checksum_error_total;
        logic [31:0]        good_total;
    } result_t;

endpackage

### rtl/lfp_frame_core.sv
// ---------------------------------------------------------------------------
// lfp_frame_core - frame hunt, checksum, unpack and counters
// Holds the frame position, byte store, running sum and error counters, and
// works out the result of one step combinationally.
// ---------------------------------------------------------------------------
module lfp_frame_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             action,
    input  logic [7:0]       rx_byte,
    input  lfp_pkg::cfg_t    cfg,
    output logic             res_valid,
    output lfp_pkg::result_t res
);

    logic [3:0]             pos_reg, pos_next;
    logic [7:0]             sum_reg, sum_next;
    logic [7:0]             frame_store [8];
    logic [COUNT_WIDTH-1:0] err_reg, err_next;
    logic [COUNT_WIDTH-1:0] ck_reg, ck_next;
    logic [COUNT_WIDTH-1:0] good_reg, good_next;
    logic                   store_wr;

    logic [15:0]            dist_raw;
    logic [19:0]            dist_mm;
    logic [15:0]            strength;
    logic [16:0]            temp_ext;
    logic [16:0]            temp_centi;

    assign dist_raw   = {frame_store[3], frame_store[2]};
    // times ten as (x << 3) + (x << 1)
    assign dist_mm    = {1'b0, dist_raw, 3'b000} + {3'b000, dist_raw, 1'b0};
    assign strength   = {frame_store[5], frame_store[4]};
    assign temp_ext   = {frame_store[7][7], frame_store[7], frame_store[6]};
    assign temp_centi = temp_ext - lfp_pkg::TEMP_OFFSET;

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    always_comb begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        err_next  = err_reg;
        ck_next   = ck_reg;
        good_next = good_reg;
        store_wr  = 1'b0;
        res_valid = 1'b0;
        res.status            = lfp_pkg::STATUS_OK;
        res.distance_mm       = '0;
        res.strength          = '0;
        res.temperature_centi = '0;
        if (step) begin
            if (action) begin
                // drop any partial frame
                pos_next        = '0;
                sum_next        = '0;
                err_next        = bump(err_reg);
                res_valid       = 1'b1;
                res.status      = lfp_pkg::STATUS_TIMEOUT;
            end else if (pos_reg < 4'd2) begin
                if (rx_byte == cfg.header_value) begin
                    store_wr = 1'b1;
                    sum_next = (pos_reg == 4'd0) ? rx_byte : sum_reg + rx_byte;
                    pos_next = pos_reg + 4'd1;
                end else begin
                    pos_next = '0;
                    sum_next = '0;
                end
            end else if (pos_reg < 4'd8) begin
                store_wr = 1'b1;
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + 4'd1;
            end else begin
                pos_next  = '0;
                sum_next  = '0;
                res_valid = 1'b1;
                if (sum_reg != rx_byte) begin
                    err_next   = bump(err_reg);
                    ck_next    = bump(ck_reg);
                    res.status = lfp_pkg::STATUS_CHECKSUM;
                end else begin
                    res.distance_mm       = dist_mm;
                    res.strength          = strength;
                    res.temperature_centi = temp_centi;
                    if (strength < cfg.min_strength) begin
                        err_next   = bump(err_reg);
                        res.status = lfp_pkg::STATUS_WEAK;
                    end else begin
                        good_next = bump(good_reg);
                        priority if (dist_mm < cfg.min_distance_mm) begin
                            res.status = lfp_pkg::STATUS_NEAR;
                        end else if (dist_mm > cfg.max_distance_mm) begin
                            res.status = lfp_pkg::STATUS_FAR;
                        end else begin
                            res.status = lfp_pkg::STATUS_OK;
                        end
                    end
                end
            end
        end
        // counters are reported on 32 bits whatever their own width
        res.error_total          = 32'(err_next);
        res.checksum_error_total = 32'(ck_next);
        res.good_total           = 32'(good_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            err_reg  <= '0;
            ck_reg   <= '0;
            good_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            err_reg  <= err_next;
            ck_reg   <= ck_next;
            good_reg <= good_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_wr) begin
            frame_store[pos_reg[2:0]] <= rx_byte;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= 4'd8)
        else $error("frame position beyond the checksum byte");

    a_timeout_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && action |=> pos_reg == 4'd0 && sum_reg == 8'd0)
        else $error("timeout left a partial frame");

    a_result_on_step: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> step && (action || pos_reg == 4'd8))
        else $error("result without a timeout or checksum byte");

    a_good_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> good_reg >= $past(good_reg) && err_reg >= $past(err_reg))
        else $error("counter went backwards");
`endif

endmodule

### rtl/lidar_frame_parser.sv
// ---------------------------------------------------------------------------
// lidar_frame_parser - rangefinder 9-byte UART frame parser
// Hunts for the double header, checks the 8-bit sum, unpacks distance,
// strength and temperature and keeps saturating error and frame counts.
// ---------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  s_        in         s_tvalid / s_tready   tdata: rx_byte, tuser: action
//  m_        out        m_tvalid / m_tready   tdata: measurement + counts,
//                                             tuser: status
//  cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte or timeout request per cycle while s_tready is high; a timeout or
// checksum byte result moves from the input register through the combinational
// frame update into the result register, which offers it on m_tvalid.
// aresetn clears the frame position, running sum, counters, both pipeline
// valids and restores the register defaults.
// A stalled m_tready holds the result and the input register; a request is
// taken only into an empty input register, then s_tready drops until the result moves on.
// ---------------------------------------------------------------------------
module lidar_frame_parser #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] rx_byte
    input  logic [0:0]   s_tuser,    // [0] action

    output logic         m_tvalid,
    input  logic         m_tready,
    // [19:0] distance_mm, [35:20] strength, [52:36] temperature_centi,
    // [84:53] error_total, [116:85] checksum_error_total,
    // [148:117] good_total, [151:149] zero
    output logic [151:0] m_tdata,
    output logic [2:0]   m_tuser,    // [2:0] status

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [19:0]  cfg_data
);

    lfp_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    logic             in_action_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    lfp_pkg::result_t out_reg;

    logic             out_free;
    logic             advance;
    logic             res_valid;
    lfp_pkg::result_t res;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_value    <= lfp_pkg::HEADER_VALUE_RST;
            cfg_reg.min_strength    <= lfp_pkg::MIN_STRENGTH_RST;
            cfg_reg.min_distance_mm <= lfp_pkg::MIN_DISTANCE_MM_RST;
            cfg_reg.max_distance_mm <= lfp_pkg::MAX_DISTANCE_MM_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lfp_pkg::CFG_HEADER_VALUE:    cfg_reg.header_value    <= cfg_data[7:0];
                lfp_pkg::CFG_MIN_STRENGTH:    cfg_reg.min_strength    <= cfg_data[15:0];
                lfp_pkg::CFG_MIN_DISTANCE_MM: cfg_reg.min_distance_mm <= cfg_data;
                lfp_pkg::CFG_MAX_DISTANCE_MM: cfg_reg.max_distance_mm <= cfg_data;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= s_tuser[0];
            in_byte_reg   <= s_tdata;
        end
    end

    lfp_frame_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .action    (in_action_reg),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'b000,
                       out_reg.good_total,
                       out_reg.checksum_error_total,
                       out_reg.error_total,
                       out_reg.temperature_centi,
                       out_reg.strength,
                       out_reg.distance_mm};

endmodule
